### rtl/afq_pkg.sv
// Shared types, codes and constants of the absmax fake quantizer.
package afq_pkg;

  localparam int COUNT_WIDTH_DEF = 24;

  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_SCAN     = 3'd1;
  localparam logic [2:0] ACT_BAND     = 3'd2;
  localparam logic [2:0] ACT_FINISH   = 3'd3;
  localparam logic [2:0] ACT_QUANTIZE = 3'd4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_MUL = 3'd1;
  localparam logic [2:0] OP_DIV = 3'd2;
  localparam logic [2:0] OP_I2F = 3'd3;
  localparam logic [2:0] OP_RND = 3'd4;

  localparam logic [1:0] REG_QUANT_BITS    = 2'd0;
  localparam logic [1:0] REG_UNSIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_RANGE_MODE    = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [31:0] quantized_value;
    logic [31:0] clipped_value;
    logic        zero_range;
    logic        finish_done;
  } out_t;

endpackage

### rtl/afq_fpu.sv
// Shared single precision unit: add, multiply, divide, integer convert and round to integer.
module afq_fpu import afq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_PREP  = 3'd1;
  localparam logic [2:0] F_PRE   = 3'd2;
  localparam logic [2:0] F_DIV   = 3'd3;
  localparam logic [2:0] F_NORM  = 3'd4;
  localparam logic [2:0] F_ROUND = 3'd5;

  localparam logic [31:0] QNAN = 32'h7FC00000;

  logic [2:0]         fstate;
  logic [2:0]         op_r;
  logic [31:0]        a_r;
  logic [31:0]        b_r;
  logic [49:0]        wm;
  logic signed [11:0] ex;
  logic               sgn;
  logic [23:0]        dma;
  logic [23:0]        dmb;
  logic signed [11:0] dea;
  logic signed [11:0] deb;
  logic [25:0]        rem;
  logic [49:0]        quo;
  logic [5:0]         cnt;

  logic [7:0]         ea_f;
  logic [7:0]         eb_f;
  logic [23:0]        ma;
  logic [23:0]        mb;
  logic signed [11:0] ea;
  logic signed [11:0] eb;
  logic               sa;
  logic               sb;
  logic               a_nan;
  logic               b_nan;
  logic               a_inf;
  logic               b_inf;
  logic               a_zero;
  logic               b_zero;

  always_comb begin
    ea_f   = a_r[30:23];
    eb_f   = b_r[30:23];
    sa     = a_r[31];
    sb     = b_r[31];
    ma     = {|ea_f, a_r[22:0]};
    mb     = {|eb_f, b_r[22:0]};
    ea     = (ea_f == 8'd0) ? 12'sd1 : $signed({4'b0, ea_f});
    eb     = (eb_f == 8'd0) ? 12'sd1 : $signed({4'b0, eb_f});
    a_nan  = (ea_f == 8'hFF) && (a_r[22:0] != 23'd0);
    b_nan  = (eb_f == 8'hFF) && (b_r[22:0] != 23'd0);
    a_inf  = (ea_f == 8'hFF) && (a_r[22:0] == 23'd0);
    b_inf  = (eb_f == 8'hFF) && (b_r[22:0] == 23'd0);
    a_zero = (a_r[30:0] == 31'd0);
    b_zero = (b_r[30:0] == 31'd0);
  end

  // Alignment and add for the add operation.
  logic               swap;
  logic [23:0]        m1;
  logic [23:0]        m2;
  logic signed [11:0] e1;
  logic               s1;
  logic               s2;
  logic [11:0]        dsh;
  logic [49:0]        w1;
  logic [49:0]        w2f;
  logic [49:0]        w2;
  logic [49:0]        lost;
  logic [49:0]        sum;
  logic               zs;

  always_comb begin
    swap = (b_r[30:0] > a_r[30:0]);
    m1   = swap ? mb : ma;
    m2   = swap ? ma : mb;
    e1   = swap ? eb : ea;
    s1   = swap ? sb : sa;
    s2   = swap ? sa : sb;
    dsh  = 12'(swap ? (eb - ea) : (ea - eb));
    w1   = {1'b0, m1, 25'b0};
    w2f  = {1'b0, m2, 25'b0};
    lost = 50'd0;
    if (dsh >= 12'd50) begin
      w2 = {49'b0, (m2 != 24'd0)};
    end else begin
      lost = w2f & ~({50{1'b1}} << dsh[5:0]);
      w2   = (w2f >> dsh[5:0]) | {49'b0, (lost != 50'd0)};
    end
    sum = (s1 == s2) ? (w1 + w2) : (w1 - w2);
    zs  = (sa == sb) ? sa : 1'b0;
  end

  logic [47:0] prod;
  assign prod = ma * mb;

  // Round to nearest integer, ties to even, for magnitudes below 2^23.
  logic [7:0]  rsh;
  logic [47:0] rx;
  logic        rinc;
  logic [24:0] rn;

  always_comb begin
    rsh  = 8'd150 - ea_f;
    rx   = {ma, 24'b0} >> rsh;
    rinc = rx[23] & ((|rx[22:0]) | rx[24]);
    rn   = (ea_f < 8'd126) ? 25'd0 : ({1'b0, rx[47:24]} + {24'b0, rinc});
  end

  // Divider step.
  logic        ge;
  logic [25:0] rsub;

  always_comb begin
    ge   = (rem >= {2'b0, dmb});
    rsub = ge ? (rem - {2'b0, dmb}) : rem;
  end

  // Final rounding and packing.
  logic               inc;
  logic [24:0]        mr;
  logic signed [11:0] exn;
  logic [23:0]        mant;
  logic [31:0]        packed_res;

  always_comb begin
    inc  = wm[24] & ((|wm[23:0]) | wm[25]);
    mr   = {1'b0, wm[48:25]} + {24'b0, inc};
    exn  = mr[24] ? (ex + 12'sd1) : ex;
    mant = mr[24] ? mr[24:1] : mr[23:0];
    if ((wm == 50'd0) || (mant == 24'd0)) begin
      packed_res = {sgn, 31'd0};
    end else if (exn >= 12'sd255) begin
      packed_res = {sgn, 8'hFF, 23'd0};
    end else begin
      packed_res = {sgn, (mant[23] ? exn[7:0] : 8'd0), mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (start) begin
            op_r   <= op;
            a_r    <= a;
            b_r    <= b;
            fstate <= F_PREP;
          end
        end
        F_PREP: begin
          fstate <= F_IDLE;
          case (op_r)
            OP_ADD: begin
              if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
                result <= QNAN;
                done   <= 1'b1;
              end else if (a_inf) begin
                result <= a_r;
                done   <= 1'b1;
              end else if (b_inf) begin
                result <= b_r;
                done   <= 1'b1;
              end else if (sum == 50'd0) begin
                result <= {zs, 31'd0};
                done   <= 1'b1;
              end else begin
                wm     <= sum;
                ex     <= e1;
                sgn    <= s1;
                fstate <= F_NORM;
              end
            end
            OP_MUL: begin
              if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                result <= QNAN;
                done   <= 1'b1;
              end else if (a_inf || b_inf) begin
                result <= {sa ^ sb, 8'hFF, 23'd0};
                done   <= 1'b1;
              end else begin
                wm     <= {prod, 2'b0};
                ex     <= ea + eb - 12'sd127;
                sgn    <= sa ^ sb;
                fstate <= F_NORM;
              end
            end
            OP_DIV: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                result <= QNAN;
                done   <= 1'b1;
              end else if (a_inf || b_zero) begin
                result <= {sa ^ sb, 8'hFF, 23'd0};
                done   <= 1'b1;
              end else if (b_inf || a_zero) begin
                result <= {sa ^ sb, 31'd0};
                done   <= 1'b1;
              end else begin
                dma    <= ma;
                dmb    <= mb;
                dea    <= ea;
                deb    <= eb;
                sgn    <= sa ^ sb;
                fstate <= F_PRE;
              end
            end
            OP_I2F: begin
              wm     <= {a_r, 18'b0};
              ex     <= 12'sd157;
              sgn    <= 1'b0;
              fstate <= F_NORM;
            end
            OP_RND: begin
              if (a_nan) begin
                result <= 32'd0;
                done   <= 1'b1;
              end else if (a_r[30:0] >= 31'h4F000000) begin
                result <= {sa, 31'h4F000000};
                done   <= 1'b1;
              end else if (ea_f >= 8'd150) begin
                result <= a_r;
                done   <= 1'b1;
              end else begin
                wm     <= {rn, 25'b0};
                ex     <= 12'sd150;
                sgn    <= sa & (rn != 25'd0);
                fstate <= F_NORM;
              end
            end
            default: begin
              result <= 32'd0;
              done   <= 1'b1;
            end
          endcase
        end
        F_PRE: begin
          if (dma[23] && dmb[23]) begin
            rem    <= {2'b0, dma};
            quo    <= 50'd0;
            cnt    <= 6'd0;
            ex     <= dea - deb + 12'sd126;
            fstate <= F_DIV;
          end else begin
            if (!dma[23]) begin
              dma <= {dma[22:0], 1'b0};
              dea <= dea - 12'sd1;
            end
            if (!dmb[23]) begin
              dmb <= {dmb[22:0], 1'b0};
              deb <= deb - 12'sd1;
            end
          end
        end
        F_DIV: begin
          quo <= {quo[48:0], ge};
          rem <= {rsub[24:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd49) begin
            wm     <= {quo[48:0], ge | (rsub != 26'd0)};
            fstate <= F_NORM;
          end
        end
        F_NORM: begin
          if (ex < -12'sd50) begin
            wm <= {49'b0, (wm != 50'd0)};
            ex <= 12'sd1;
          end else if (wm[49] || (ex < 12'sd1)) begin
            wm <= {1'b0, wm[49:2], wm[1] | wm[0]};
            ex <= ex + 12'sd1;
          end else if (!wm[48] && (ex > 12'sd1) && (wm != 50'd0)) begin
            wm <= {wm[48:0], 1'b0};
            ex <= ex - 12'sd1;
          end else begin
            fstate <= F_ROUND;
          end
        end
        F_ROUND: begin
          result <= packed_res;
          done   <= 1'b1;
          fstate <= F_IDLE;
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/absmax_fake_quantizer.sv
// Top level of the absmax fake quantizer: request sequencer, statistics and scales.
//
//   channel   direction  signals                        handshake
//   in        input      in_data (action, value)        in_valid / in_ready
//   out       output     out_data (quantized, clipped)  out_valid / out_ready
//   cfg       input      cfg_index, cfg_data            cfg_we, no wait
//
// Clear and scan requests are applied directly from the idle state. Band, finish
// and quantize requests run one float operation at a time on the shared unit; an
// operation's length is set by the one-bit-a-cycle normalize loop, the divider's
// operand pre-shift and its 50 steps. A band request costs 2 to 3 operations,
// quantize 3 (none for a zero range), finish up to 8 (three divides).
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block a new request until that request needs the register.
// Reset is synchronous and clears all statistics, scales and output handshake flags.
module absmax_fake_quantizer import afq_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BHI   = 4'd1;
  localparam logic [3:0] S_BLO   = 4'd2;
  localparam logic [3:0] S_BADD  = 4'd3;
  localparam logic [3:0] S_FI2F  = 4'd4;
  localparam logic [3:0] S_FMEAN = 4'd5;
  localparam logic [3:0] S_FD1   = 4'd6;
  localparam logic [3:0] S_FD2   = 4'd7;
  localparam logic [3:0] S_FRNG  = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_FQMAX = 4'd10;
  localparam logic [3:0] S_FQS   = 4'd11;
  localparam logic [3:0] S_FDS   = 4'd12;
  localparam logic [3:0] S_QMUL  = 4'd13;
  localparam logic [3:0] S_QRND  = 4'd14;
  localparam logic [3:0] S_QDEQ  = 4'd15;

  localparam logic [31:0] C_075 = 32'h3F400000;
  localparam logic [31:0] C_09  = 32'h3F666666;
  localparam logic [31:0] C_1   = 32'h3F800000;

  function automatic logic f_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    return (x[30:0] == 31'd0);
  endfunction

  function automatic logic [31:0] f_key(input logic [31:0] x);
    return x[31] ? ~x : (x | 32'h80000000);
  endfunction

  function automatic logic f_lt(input logic [31:0] x, input logic [31:0] y);
    if (f_nan(x) || f_nan(y) || (f_zero(x) && f_zero(y))) begin
      return 1'b0;
    end
    return f_key(x) < f_key(y);
  endfunction

  logic [3:0]             state;
  logic                   issued;
  logic                   out_pending;
  logic                   is_fin;
  logic [4:0]             quant_bits;
  logic                   unsigned_mode;
  logic                   range_mode;
  logic [31:0]            abs_peak;
  logic [31:0]            run_min;
  logic [31:0]            run_max;
  logic [31:0]            band_sum;
  logic [COUNT_WIDTH-1:0] item_count;
  logic [31:0]            range_value;
  logic [31:0]            quant_scale;
  logic [31:0]            dequant_scale;
  logic [31:0]            tmp1;
  logic [31:0]            mean;
  logic [31:0]            qres;
  logic [31:0]            clip_r;
  logic [31:0]            val_r;

  logic        fpu_step;
  logic        fpu_start;
  logic [2:0]  fpu_op;
  logic [31:0] fpu_a;
  logic [31:0] fpu_b;
  logic        fpu_done;
  logic [31:0] fpu_res;

  logic [4:0]  qb;
  logic [24:0] qmax;
  logic [31:0] neg_mean;
  logic [31:0] neg_range;
  logic [31:0] clip_next;
  logic        accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE) && !out_pending;
  assign neg_mean  = {~mean[31], mean[30:0]};
  assign neg_range = {~range_value[31], range_value[30:0]};

  always_comb begin
    if (quant_bits < 5'd2) begin
      qb = 5'd2;
    end else if (quant_bits > 5'd24) begin
      qb = 5'd24;
    end else begin
      qb = quant_bits;
    end
    qmax = (25'd1 << (unsigned_mode ? qb : (qb - 5'd1))) - 25'd1;
    if (f_nan(in_data.value) || f_lt(range_value, in_data.value)) begin
      clip_next = range_value;
    end else if (f_lt(in_data.value, neg_range)) begin
      clip_next = neg_range;
    end else begin
      clip_next = in_data.value;
    end
  end

  always_comb begin
    fpu_step = 1'b1;
    fpu_op   = OP_ADD;
    fpu_a    = 32'd0;
    fpu_b    = 32'd0;
    unique case (state)
      S_BHI: begin
        fpu_op = OP_MUL;
        fpu_a  = run_max;
        fpu_b  = C_075;
      end
      S_BLO: begin
        fpu_op = OP_MUL;
        fpu_a  = run_min;
        fpu_b  = C_075;
      end
      S_BADD: begin
        fpu_a = band_sum;
        fpu_b = val_r;
      end
      S_FI2F: begin
        fpu_op = OP_I2F;
        fpu_a  = 32'(item_count);
      end
      S_FMEAN: begin
        fpu_op = OP_DIV;
        fpu_a  = band_sum;
        fpu_b  = tmp1;
      end
      S_FD1: begin
        fpu_a = run_min;
        fpu_b = neg_mean;
      end
      S_FD2: begin
        fpu_a = run_max;
        fpu_b = neg_mean;
      end
      S_FRNG: begin
        fpu_op = OP_MUL;
        fpu_a  = C_09;
        fpu_b  = tmp1;
      end
      S_FQMAX: begin
        fpu_op = OP_I2F;
        fpu_a  = {8'd0, qmax[23:0]};
      end
      S_FQS: begin
        fpu_op = OP_DIV;
        fpu_a  = tmp1;
        fpu_b  = range_value;
      end
      S_FDS: begin
        fpu_op = OP_DIV;
        fpu_a  = C_1;
        fpu_b  = quant_scale;
      end
      S_QMUL: begin
        fpu_op = OP_MUL;
        fpu_a  = clip_r;
        fpu_b  = quant_scale;
      end
      S_QRND: begin
        fpu_op = OP_RND;
        fpu_a  = tmp1;
      end
      S_QDEQ: begin
        fpu_op = OP_MUL;
        fpu_a  = tmp1;
        fpu_b  = dequant_scale;
      end
      default: fpu_step = 1'b0;
    endcase
  end

  assign fpu_start = fpu_step && !issued;

  afq_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      out_valid     <= 1'b0;
      out_pending   <= 1'b0;
      is_fin        <= 1'b0;
      quant_bits    <= 5'd8;
      unsigned_mode <= 1'b0;
      range_mode    <= 1'b0;
      abs_peak      <= 32'd0;
      run_min       <= 32'd0;
      run_max       <= 32'd0;
      band_sum      <= 32'd0;
      item_count    <= '0;
      range_value   <= 32'd0;
      quant_scale   <= 32'd0;
      dequant_scale <= 32'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_QUANT_BITS:    quant_bits    <= cfg_data;
          REG_UNSIGNED_MODE: unsigned_mode <= cfg_data[0];
          REG_RANGE_MODE:    range_mode    <= cfg_data[0];
          default: ;
        endcase
      end

      if (fpu_start) begin
        issued <= 1'b1;
      end
      if (fpu_done) begin
        issued <= 1'b0;
      end

      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_pending && (!out_valid || out_ready)) begin
        out_valid                <= 1'b1;
        out_pending              <= 1'b0;
        out_data.quantized_value <= is_fin ? range_value : qres;
        out_data.clipped_value   <= is_fin ? 32'd0 : clip_r;
        out_data.zero_range      <= f_zero(range_value);
        out_data.finish_done     <= is_fin;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val_r <= in_data.value;
            case (in_data.action)
              ACT_CLEAR: begin
                abs_peak      <= 32'd0;
                run_min       <= 32'd0;
                run_max       <= 32'd0;
                band_sum      <= 32'd0;
                item_count    <= '0;
                range_value   <= 32'd0;
                quant_scale   <= 32'd0;
                dequant_scale <= 32'd0;
              end
              ACT_SCAN: begin
                if (f_lt(abs_peak, {1'b0, in_data.value[30:0]})) begin
                  abs_peak <= {1'b0, in_data.value[30:0]};
                end
                if (f_lt(in_data.value, run_min)) begin
                  run_min <= in_data.value;
                end
                if (f_lt(run_max, in_data.value)) begin
                  run_max <= in_data.value;
                end
                if (item_count != {COUNT_WIDTH{1'b1}}) begin
                  item_count <= item_count + 1'b1;
                end
              end
              ACT_BAND: state <= S_BHI;
              ACT_FINISH: begin
                is_fin <= 1'b1;
                if (!range_mode) begin
                  range_value <= abs_peak;
                  state       <= S_FCHK;
                end else if (!(f_lt(run_min, 32'd0) && f_lt(32'd0, run_max))) begin
                  range_value <= 32'd0;
                  state       <= S_FCHK;
                end else if (item_count != '0) begin
                  state <= S_FI2F;
                end else begin
                  mean  <= 32'd0;
                  state <= S_FD1;
                end
              end
              ACT_QUANTIZE: begin
                is_fin <= 1'b0;
                clip_r <= clip_next;
                if (f_zero(range_value)) begin
                  qres        <= 32'd0;
                  out_pending <= 1'b1;
                end else begin
                  state <= S_QMUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_FCHK: begin
          if (f_zero(range_value)) begin
            quant_scale   <= 32'd0;
            dequant_scale <= 32'd0;
            out_pending   <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_FQMAX;
          end
        end
        default: begin
          if (fpu_done) begin
            case (state)
              S_BHI: begin
                tmp1  <= fpu_res;
                state <= S_BLO;
              end
              S_BLO: begin
                if (f_lt(val_r, tmp1) && f_lt(fpu_res, val_r)) begin
                  state <= S_BADD;
                end else begin
                  state <= S_IDLE;
                end
              end
              S_BADD: begin
                band_sum <= fpu_res;
                state    <= S_IDLE;
              end
              S_FI2F: begin
                tmp1  <= fpu_res;
                state <= S_FMEAN;
              end
              S_FMEAN: begin
                mean  <= fpu_res;
                state <= S_FD1;
              end
              S_FD1: begin
                tmp1  <= fpu_res;
                state <= S_FD2;
              end
              S_FD2: begin
                if (f_lt({1'b0, tmp1[30:0]}, {1'b0, fpu_res[30:0]})) begin
                  tmp1 <= {1'b0, run_min[30:0]};
                end else begin
                  tmp1 <= {1'b0, run_max[30:0]};
                end
                state <= S_FRNG;
              end
              S_FRNG: begin
                range_value <= fpu_res;
                state       <= S_FCHK;
              end
              S_FQMAX: begin
                tmp1  <= fpu_res;
                state <= S_FQS;
              end
              S_FQS: begin
                quant_scale <= fpu_res;
                if (f_zero(fpu_res)) begin
                  dequant_scale <= 32'd0;
                  out_pending   <= 1'b1;
                  state         <= S_IDLE;
                end else begin
                  state <= S_FDS;
                end
              end
              S_FDS: begin
                dequant_scale <= fpu_res;
                out_pending   <= 1'b1;
                state         <= S_IDLE;
              end
              S_QMUL: begin
                tmp1  <= fpu_res;
                state <= S_QRND;
              end
              S_QRND: begin
                tmp1  <= fpu_res;
                state <= S_QDEQ;
              end
              S_QDEQ: begin
                qres        <= fpu_res;
                out_pending <= 1'b1;
                state       <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  a_done_in_step: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> (state != S_IDLE) && (state != S_FCHK) && issued)
    else $error("float unit finished with no operation pending");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.action == ACT_FINISH)) |=> !in_ready)
    else $error("finish request did not hold off the next request");

  a_finish_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.finish_done) |-> (out_data.clipped_value == 32'd0))
    else $error("finish result carries a clipped value");

  a_range_sign: assert property (@(posedge clk) disable iff (rst)
    !range_value[31])
    else $error("range value became negative");

endmodule

### bench/absmax_fake_quantizer_test.sv
// Self-checking testbench of absmax_fake_quantizer with a single-precision predictor.
module absmax_fake_quantizer_test;
  import afq_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int SETTLE_CYCLES = 500;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [31:0] F_ZERO = 32'h00000000;
  localparam logic [31:0] F_ONE = 32'h3F800000;
  localparam logic [31:0] F_HALF = 32'h3F000000;
  localparam logic [31:0] F_THREE_QUARTERS = 32'h3F400000;
  localparam logic [31:0] F_NINE_TENTHS = 32'h3F666666;
  localparam logic [31:0] F_TWO_POW_31 = 32'h4F000000;
  localparam logic [31:0] F_NEG_TWO_POW_31 = 32'hCF000000;
  localparam logic [31:0] F_INF = 32'h7F800000;
  localparam logic [31:0] F_NAN = 32'h7FC00000;

  typedef struct {
    logic [2:0] action;
    logic [31:0] value;
    bit literal;
    out_t result;
  } plan_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  logic [4:0] shadow_bits;
  logic shadow_unsigned;
  logic shadow_range_mode;
  logic [31:0] abs_peak;
  logic [31:0] run_min;
  logic [31:0] run_max;
  logic [31:0] band_sum;
  logic [23:0] item_count;
  logic [31:0] range_value;
  logic [31:0] quant_scale;
  logic [31:0] dequant_scale;

  out_t awaited_results[$];
  int mismatches;
  longint cycles;
  int burst_left;
  int sent;
  logic [31:0] sample_pool[$];

  plan_row_t plan [22] = '{
    '{ACT_FINISH, F_ZERO, 1'b1, {F_ZERO, F_ZERO, 1'b1, 1'b1}},
    '{ACT_QUANTIZE, F_ONE, 1'b1, {F_ZERO, F_ZERO, 1'b1, 1'b0}},
    '{ACT_QUANTIZE, 32'hC0000000, 1'b1, {F_ZERO, 32'h80000000, 1'b1, 1'b0}},
    '{ACT_SCAN, F_ONE, 1'b0, '0},
    '{ACT_SCAN, 32'hC0600000, 1'b0, '0},
    '{ACT_SCAN, F_NAN, 1'b0, '0},
    '{ACT_SCAN, 32'h00000001, 1'b0, '0},
    '{ACT_BAND, F_HALF, 1'b0, '0},
    '{ACT_BAND, F_NAN, 1'b0, '0},
    '{ACT_FINISH, F_ZERO, 1'b0, '0},
    '{ACT_QUANTIZE, 32'h40000000, 1'b0, '0},
    '{ACT_QUANTIZE, 32'hC0A00000, 1'b0, '0},
    '{ACT_QUANTIZE, F_NAN, 1'b0, '0},
    '{ACT_QUANTIZE, F_HALF, 1'b0, '0},
    '{ACT_QUANTIZE, 32'h80000000, 1'b0, '0},
    '{3'd5, 32'hFFFFFFFF, 1'b0, '0},
    '{3'd6, F_ONE, 1'b0, '0},
    '{3'd7, F_ZERO, 1'b0, '0},
    '{ACT_CLEAR, 32'h12345678, 1'b0, '0},
    '{ACT_FINISH, F_ZERO, 1'b1, {F_ZERO, F_ZERO, 1'b1, 1'b1}},
    '{ACT_SCAN, 32'hFF800000, 1'b0, '0},
    '{ACT_FINISH, F_ZERO, 1'b0, '0}
  };

  absmax_fake_quantizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic real to_real(logic [31:0] b);
    logic [63:0] d;
    int e;
    e = b[30:23];
    if (e == 0) return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
    if (e == 255) d = {b[31], 11'h7FF, b[22:0], 29'b0};
    else d = {b[31], 11'(e - 127 + 1023), b[22:0], 29'b0};
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] to_single(real r);
    logic [63:0] d, sig, keep, rem, half;
    logic [31:0] m;
    int e, fe, sh;
    bit up;
    d = $realtobits(r);
    e = d[62:52];
    if (e == 2047) return d[51:0] != 0 ? F_NAN : {d[63], F_INF[30:0]};
    if (e == 0) return {d[63], 31'b0};
    fe = e - 1023 + 127;
    if (fe >= 255) return {d[63], F_INF[30:0]};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 60) return {d[63], 31'b0};
    sig = {11'b0, 1'b1, d[51:0]};
    keep = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    up = rem > half || (rem == half && keep[0]);
    if (fe >= 1) m = (32'(fe) << 23) + 32'(keep[22:0]) + 32'(up);
    else m = 32'(keep) + 32'(up);
    return {d[63], m[30:0]};
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) + to_real(b));
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) - to_real(b));
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) * to_real(b));
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) / to_real(b));
  endfunction

  function automatic bit f_less(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && to_real(a) < to_real(b);
  endfunction

  function automatic logic [31:0] round_half_even(logic [31:0] p);
    real pr, fr;
    longint t;
    if (is_nan(p)) return F_ZERO;
    pr = to_real(p);
    if (pr >= 2147483648.0) return F_TWO_POW_31;
    if (pr <= -2147483648.0) return F_NEG_TWO_POW_31;
    t = $rtoi(pr);
    fr = to_real(f_sub(p, to_single(real'(t))));
    if (fr > 0.5 || (fr == 0.5 && t[0])) t = t + 1;
    else if (fr < -0.5 || (fr == -0.5 && t[0])) t = t - 1;
    return to_single(real'(t));
  endfunction

  function automatic void clear_statistics();
    abs_peak = F_ZERO;
    run_min = F_ZERO;
    run_max = F_ZERO;
    band_sum = F_ZERO;
    item_count = '0;
    range_value = F_ZERO;
    quant_scale = F_ZERO;
    dequant_scale = F_ZERO;
  endfunction

  function automatic void settle_range();
    int nbits;
    longint qmax;
    logic [31:0] mean, mag;
    nbits = shadow_bits < 2 ? 2 : (shadow_bits > 24 ? 24 : shadow_bits);
    qmax = shadow_unsigned ? (64'd1 << nbits) - 1 : (64'd1 << (nbits - 1)) - 1;
    if (!shadow_range_mode) begin
      range_value = abs_peak;
    end else begin
      mean = item_count != 0 ? f_div(band_sum, to_single(real'(item_count))) : F_ZERO;
      range_value = F_ZERO;
      if (f_less(run_min, F_ZERO) && f_less(F_ZERO, run_max)) begin
        mag = f_sub(run_max, mean) & 32'h7FFFFFFF;
        if (f_less(f_sub(run_min, mean) & 32'h7FFFFFFF, mag))
          range_value = f_mul(F_NINE_TENTHS, run_min & 32'h7FFFFFFF);
        else
          range_value = f_mul(F_NINE_TENTHS, run_max & 32'h7FFFFFFF);
      end
    end
    if (to_real(range_value) == 0.0) begin
      quant_scale = F_ZERO;
      dequant_scale = F_ZERO;
    end else begin
      quant_scale = f_div(to_single(real'(qmax)), range_value);
      dequant_scale = to_real(quant_scale) != 0.0 ? f_div(F_ONE, quant_scale) : F_ZERO;
    end
  endfunction

  function automatic bit apply_request(in_t req, output out_t res);
    logic [31:0] v, mag, r, c, q;
    v = req.value;
    res = '0;
    case (req.action)
      ACT_CLEAR: begin
        clear_statistics();
        return 0;
      end
      ACT_SCAN: begin
        mag = v & 32'h7FFFFFFF;
        if (f_less(abs_peak, mag)) abs_peak = mag;
        if (f_less(v, run_min)) run_min = v;
        if (f_less(run_max, v)) run_max = v;
        if (item_count != 24'hFFFFFF) item_count = item_count + 1;
        return 0;
      end
      ACT_BAND: begin
        if (f_less(v, f_mul(run_max, F_THREE_QUARTERS)) &&
            f_less(f_mul(run_min, F_THREE_QUARTERS), v))
          band_sum = f_add(band_sum, v);
        return 0;
      end
      ACT_FINISH: begin
        settle_range();
        res.quantized_value = range_value;
        res.zero_range = to_real(range_value) == 0.0;
        res.finish_done = 1'b1;
        return 1;
      end
      ACT_QUANTIZE: begin
        r = range_value;
        if (is_nan(v) || f_less(r, v)) c = r;
        else if (f_less(v, r ^ 32'h80000000)) c = r ^ 32'h80000000;
        else c = v;
        q = F_ZERO;
        if (to_real(r) != 0.0)
          q = f_mul(round_half_even(f_mul(c, quant_scale)), dequant_scale);
        res.quantized_value = q;
        res.clipped_value = c;
        res.zero_range = to_real(r) == 0.0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_request(logic [2:0] action, logic [31:0] value,
                              bit literal = 0, out_t literal_result = '0);
    in_t req;
    out_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    burst_left--;
    req.action = action;
    req.value = value;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (apply_request(req, res)) awaited_results.push_back(literal ? literal_result : res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [4:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_QUANT_BITS: shadow_bits = data;
      REG_UNSIGNED_MODE: shadow_unsigned = data[0];
      REG_RANGE_MODE: shadow_range_mode = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_sample(int spread);
    logic [31:0] specials [8] = '{F_ZERO, 32'h80000000, F_INF, 32'hFF800000, F_NAN,
                                  32'h007FFFFF, 32'h7F7FFFFF, 32'hFFFFFFFF};
    case ($urandom_range(0, 19))
      0: return $urandom();
      1: return specials[$urandom_range(0, 7)];
      default: return {1'($urandom()), 8'(127 + $urandom_range(0, 2 * spread) - spread),
                       23'($urandom())};
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    case ((cycles / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= $urandom_range(0, 7) == 0;
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL absmax_fake_quantizer");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result %h", out_data);
      end else begin
        if (out_data !== awaited_results[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected q=%h c=%h z=%b f=%b, got q=%h c=%h z=%b f=%b",
                     awaited_results[0].quantized_value, awaited_results[0].clipped_value,
                     awaited_results[0].zero_range, awaited_results[0].finish_done,
                     out_data.quantized_value, out_data.clipped_value,
                     out_data.zero_range, out_data.finish_done);
        end
        void'(awaited_results.pop_front());
      end
    end
  end

  initial begin
    int nscan, nquant;
    logic [4:0] bits_choice [6] = '{5'd0, 5'd1, 5'd2, 5'd24, 5'd25, 5'd31};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    mismatches = 0;
    burst_left = 0;
    sent = 0;
    shadow_bits = 5'd8;
    shadow_unsigned = 1'b0;
    shadow_range_mode = 1'b0;
    clear_statistics();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_request(plan[i].action, plan[i].value, plan[i].literal,
                                   plan[i].result);
    drain();

    while (sent < ITEM_TARGET + 22) begin
      write_reg(REG_QUANT_BITS, $urandom_range(0, 3) == 0 ?
                bits_choice[$urandom_range(0, 5)] : 5'($urandom_range(0, 31)));
      write_reg(REG_UNSIGNED_MODE, 5'($urandom_range(0, 31)));
      write_reg(REG_RANGE_MODE, 5'($urandom_range(0, 31)));
      if ($urandom_range(0, 4) == 0) write_reg(2'd3, 5'($urandom_range(0, 31)));
      send_request(ACT_CLEAR, $urandom());
      sample_pool.delete();
      nscan = $urandom_range(1, 30);
      repeat (nscan) begin
        sample_pool.push_back(random_sample(6));
        send_request(ACT_SCAN, sample_pool[$]);
      end
      foreach (sample_pool[i]) begin
        if ($urandom_range(0, 9) == 0) send_request(3'($urandom_range(0, 7)), $urandom());
        send_request(ACT_BAND, $urandom_range(0, 5) == 0 ? random_sample(6) : sample_pool[i]);
      end
      send_request(ACT_FINISH, $urandom());
      nquant = $urandom_range(1, 30);
      repeat (nquant) begin
        if ($urandom_range(0, 9) == 0) send_request(3'($urandom_range(0, 7)), $urandom());
        send_request(ACT_QUANTIZE, random_sample(8));
      end
      if ($urandom_range(0, 3) == 0) send_request(ACT_FINISH, $urandom());
      drain();
    end

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS absmax_fake_quantizer");
    end else begin
      $display("FAIL absmax_fake_quantizer");
    end
    $finish;
  end

endmodule
